/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue unit
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int WORD_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    // request kinds
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 2'd0,
        OP_POP_FRONT   = 2'd1,
        OP_INJECT_REAR = 2'd2,
        OP_EJECT_REAR  = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell, already qualified by success
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic inject_rear;
        logic eject_rear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// one slot of the queue chain: a data word and an occupied flag
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire deq_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [deq_pkg::WORD_W-1:0] i_value,
    input  wire logic [deq_pkg::WORD_W-1:0] i_left_data,
    input  wire logic                       i_left_occ,
    input  wire logic [deq_pkg::WORD_W-1:0] i_right_data,
    input  wire logic                       i_right_occ,
    output logic      [deq_pkg::WORD_W-1:0] o_data,
    output logic                            o_occ,
    output logic      [deq_pkg::WORD_W-1:0] o_rear_data
);
    import deq_pkg::*;

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic              r_occ;
    logic              n_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        if (i_ctrl.push_front) begin
            // shift toward the rear
            n_data = i_left_data;
            n_occ  = i_left_occ;
        end else if (i_ctrl.pop_front) begin
            // shift toward the front
            n_data = i_right_data;
            n_occ  = i_right_occ;
        end else if (i_ctrl.inject_rear) begin
            // first free slot takes the word
            if (!r_occ && i_left_occ) begin
                n_data = i_value;
            end
            n_occ = r_occ | i_left_occ;
        end else if (i_ctrl.eject_rear) begin
            // last occupied slot frees itself
            n_occ = r_occ & i_right_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_data      = r_data;
    assign o_occ       = r_occ;
    // only the rear slot shows its word, so an or over the chain picks it
    assign o_rear_data = (r_occ && !i_right_occ) ? r_data : '0;

endmodule

`default_nettype wire

/* rtl/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue of 32-bit signed words built as a chain of cells
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH words in a row of cells with the front always in
// the first cell. Push front and pop front shift the whole row by one cell;
// inject rear writes the first free cell and eject rear frees the last
// occupied one, so the occupied flags form a thermometer that doubles as the
// fill level. Every request is decided and applied to the
// cells at the edge where it is transferred, and its single result lands in
// the output register at that same edge. The output register lets a new
// request in while its result waits, so with the result side ready the unit
// sustains one request per clock; it stalls only while the output register is
// full and not drained. A removal from an empty queue answers empty, an
// insertion into a full queue answers full, and neither changes the contents.
// Words start undefined after reset; only words that were written are read.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request side
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [deq_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] value_in
    input  wire logic [deq_pkg::OP_W-1:0]     s_axis_tuser,  // [1:0] req_type
    // result side
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [deq_pkg::WORD_W-1:0]   m_axis_tdata,  // [31:0] value_out
    output logic      [deq_pkg::STATUS_W-1:0] m_axis_tuser   // [1:0] status
);
    import deq_pkg::*;

    // cell chain views
    logic [WORD_W-1:0] w_data [DEPTH];
    logic [WORD_W-1:0] w_rear [DEPTH];
    logic [DEPTH-1:0]  w_occ;
    logic [WORD_W-1:0] w_rear_word;

    // request decode
    logic       w_s_xfer;
    t_op        w_op;
    logic       w_empty;
    logic       w_full;
    t_cell_ctrl w_ctrl;

    // output register
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_data;
    t_status             r_out_status;
    logic [WORD_W-1:0]   n_out_data;
    t_status             n_out_status;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_s_xfer      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);

    // thermometer: first cell holds the front, last cell set means full
    assign w_empty = !w_occ[0];
    assign w_full  = w_occ[DEPTH-1];

    // only successful requests touch the cells
    always_comb begin
        w_ctrl             = '0;
        w_ctrl.push_front  = w_s_xfer && (w_op == OP_PUSH_FRONT)  && !w_full;
        w_ctrl.pop_front   = w_s_xfer && (w_op == OP_POP_FRONT)   && !w_empty;
        w_ctrl.inject_rear = w_s_xfer && (w_op == OP_INJECT_REAR) && !w_full;
        w_ctrl.eject_rear  = w_s_xfer && (w_op == OP_EJECT_REAR)  && !w_empty;
    end

    // chain of cells, cell 0 is the front
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_left_data;
        logic              w_left_occ;
        logic [WORD_W-1:0] w_right_data;
        logic              w_right_occ;

        if (g == 0) begin : g_first
            // a push front feeds the new word in ahead of the row
            assign w_left_data = s_axis_tdata;
            assign w_left_occ  = 1'b1;
        end else begin : g_inner_left
            assign w_left_data = w_data[g-1];
            assign w_left_occ  = w_occ[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            // nothing lies beyond the last cell
            assign w_right_data = '0;
            assign w_right_occ  = 1'b0;
        end else begin : g_inner_right
            assign w_right_data = w_data[g+1];
            assign w_right_occ  = w_occ[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (s_axis_tdata),
            .i_left_data  (w_left_data),
            .i_left_occ   (w_left_occ),
            .i_right_data (w_right_data),
            .i_right_occ  (w_right_occ),
            .o_data       (w_data[g]),
            .o_occ        (w_occ[g]),
            .o_rear_data  (w_rear[g])
        );
    end

    // at most one cell drives a nonzero rear word
    always_comb begin
        w_rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_word = w_rear_word | w_rear[i];
        end
    end

    // result of the request in flight
    always_comb begin
        n_out_data   = '0;
        n_out_status = ST_OK;
        unique case (w_op)
            OP_PUSH_FRONT, OP_INJECT_REAR: begin
                if (w_full) begin
                    n_out_status = ST_FULL;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_out_data = w_data[0];
                end
            end
            OP_EJECT_REAR: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_out_data = w_rear_word;
                end
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // occupied flags always form a contiguous run from the front
    a_occ_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ[DEPTH-1:1] & ~w_occ[DEPTH-2:0]) == '0)
        else $error("occupied cells not contiguous from the front");

    // a removal from an empty queue answers empty with a zero word
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && w_empty &&
         (w_op == OP_POP_FRONT || w_op == OP_EJECT_REAR))
        |=> (m_axis_tuser == ST_EMPTY) && (m_axis_tdata == '0))
        else $error("empty removal answered wrongly");

    // an insertion into a full queue leaves the fill level alone
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && w_full &&
         (w_op == OP_PUSH_FRONT || w_op == OP_INJECT_REAR))
        |=> (m_axis_tuser == ST_FULL) && $stable(w_occ))
        else $error("full insertion changed the queue");

    // a pop returns the word that sat in the front cell
    a_pop_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && !w_empty && (w_op == OP_POP_FRONT))
        |=> (m_axis_tdata == $past(w_data[0])) && (m_axis_tuser == ST_OK))
        else $error("pop front returned the wrong word");

endmodule

`default_nettype wire

/* sim/tb_double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// self-checking bench for the bounded double-ended queue unit
// ----------------------------------------------------------------------------
// A request list is built up front: a short directed run hits removal from an
// empty queue, insertion into a full queue and the word extremes. It is
// followed by random segments that lean toward filling, draining or mixing so
// the ring keeps crossing full and empty. A driver block feeds requests with
// random gaps. Every accepted transfer runs through a ring predictor, and the
// predicted result is queued. A monitor block stalls the result side at
// random and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_double_ended_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1000;
    localparam int SEGMENT_LEN  = 48;
    localparam int MAX_WAIT     = 16;

    // one queued request with its pre-gap and an optional drain hold-off
    typedef struct {
        t_op         op;
        logic [31:0] word;
        int          gap;
        bit          hold_for_drain;
    } t_deq_request;

    // one predicted result
    typedef struct {
        logic [31:0] word;
        t_status     status;
    } t_deq_result;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request side, driven from the start
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata  = '0;  // [31:0] value_in
    logic [OP_W-1:0]     s_axis_tuser  = '0;  // [1:0] req_type

    // result side
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [WORD_W-1:0]   m_axis_tdata;        // [31:0] value_out
    logic [STATUS_W-1:0] m_axis_tuser;        // [1:0] status

    // stimulus and expectation stores
    t_deq_request request_queue[$];
    t_deq_result  expected_results[$];
    int           requests_total    = 0;
    int           requests_accepted = 0;
    int           error_count       = 0;

    // predictor copy of the ring
    logic [31:0] ring_words [DEPTH];
    int          ring_head = 0;
    int          ring_fill = 0;

    // driver working state
    t_deq_request staged_request;
    t_deq_request live_request;
    bit           staged    = 1'b0;
    int           gap_left  = 0;

    // monitor working state
    int rx_wait  = 0;
    bit rx_quiet = 1'b0;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // apply one request to the ring copy and return what the unit must answer
    function automatic t_deq_result predict_deque(t_deq_request req);
        t_deq_result res;
        int          slot;
        res.word   = '0;
        res.status = ST_OK;
        case (req.op)
            OP_PUSH_FRONT: begin
                if (ring_fill == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ring_head             = (ring_head + DEPTH - 1) % DEPTH;
                    ring_words[ring_head] = req.word;
                    ring_fill++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.word  = ring_words[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            OP_INJECT_REAR: begin
                if (ring_fill == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot             = (ring_head + ring_fill) % DEPTH;
                    ring_words[slot] = req.word;
                    ring_fill++;
                end
            end
            default: begin
                if (ring_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ring_fill--;
                    slot     = (ring_head + ring_fill) % DEPTH;
                    res.word = ring_words[slot];
                end
            end
        endcase
        return res;
    endfunction

    task automatic add_request(t_op op, logic [31:0] word, int gap, bit hold);
        t_deq_request req;
        req.op             = op;
        req.word           = word;
        req.gap            = gap;
        req.hold_for_drain = hold;
        request_queue.push_back(req);
        requests_total++;
    endtask

    // edge-heavy word picker: extremes, zero, all ones, small, or fully random
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // stimulus build and end of run
    initial begin
        int   seg_kind;
        bit   seg_quiet;
        bit   inserting;
        t_op  op;
        int   gap;

        // directed: removal on empty, sixteen inserts with extremes, full, removals
        add_request(OP_POP_FRONT,  32'hFFFF_FFFF, 0, 1'b0);
        add_request(OP_EJECT_REAR, 32'h0000_0000, 0, 1'b0);
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0:       add_request(OP_PUSH_FRONT,  32'h7FFF_FFFF - i, 0, 1'b0);
                1:       add_request(OP_INJECT_REAR, 32'h8000_0000 + i, 0, 1'b0);
                2:       add_request(OP_PUSH_FRONT,  32'(i), 0, 1'b0);
                default: add_request(OP_INJECT_REAR, ~32'(i), 0, 1'b0);
            endcase
        end
        add_request(OP_PUSH_FRONT,  32'h1234_5678, 0, 1'b0);
        add_request(OP_INJECT_REAR, 32'hDEAD_BEEF, 0, 1'b0);
        add_request(OP_POP_FRONT,   32'h0000_0000, 0, 1'b0);
        add_request(OP_EJECT_REAR,  32'hFFFF_FFFF, 0, 1'b0);

        // random segments: fill-leaning, drain-leaning or balanced
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                seg_kind  = $urandom_range(0, 2);
                seg_quiet = ($urandom_range(0, 3) == 0);
            end
            case (seg_kind)
                0:       inserting = ($urandom_range(0, 99) < 80);
                1:       inserting = ($urandom_range(0, 99) < 20);
                default: inserting = ($urandom_range(0, 1) == 1);
            endcase
            if (inserting)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_INJECT_REAR;
            else
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_EJECT_REAR;
            gap = seg_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            // hold the sender until all results are back at some segment starts
            add_request(op, pick_word(), gap,
                        (n % SEGMENT_LEN == 0) && ($urandom_range(0, 2) == 0 || n == 0));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_accepted < requests_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        // give a stray extra result a chance to show up
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // request driver: predicts on each transfer, then stages the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            staged        = 1'b0;
            gap_left      = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_deque(live_request));
                requests_accepted++;
            end
            // slot is free unless a request is still waiting for ready
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (!staged && request_queue.size() != 0 &&
                    !(request_queue[0].hold_for_drain && expected_results.size() != 0)) begin
                    staged_request = request_queue.pop_front();
                    staged         = 1'b1;
                    gap_left       = staged_request.gap;
                end
                if (staged && gap_left == 0) begin
                    live_request  = staged_request;
                    staged        = 1'b0;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= staged_request.word;
                    s_axis_tuser  <= staged_request.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (staged)
                        gap_left--;
                end
            end
        end
    end

    // result monitor: random back-pressure, field by field compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: value_out %0d status %0d",
                           $signed(m_axis_tdata), m_axis_tuser);
                    error_count++;
                end else begin
                    t_deq_result exp_res;
                    exp_res = expected_results.pop_front();
                    if (m_axis_tdata !== exp_res.word) begin
                        $error("value_out: expected %0d, actual %0d",
                               $signed(exp_res.word), $signed(m_axis_tdata));
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, m_axis_tuser);
                        error_count++;
                    end
                end
                // switch between stall-free stretches and random stalls now and then
                if ($urandom_range(0, 99) < 4)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
